@@ src/ckh_pkg.sv @@
// Shared types and operation codes for the cuckoo hash table.
package ckh_pkg;

  // Operation field of an input word.
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_LOOKUP = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

endpackage

@@ src/ckh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ckh_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/cuckoo_hash_table.sv @@
// Top level of the two-table cuckoo hash set.
//
// Two-table cuckoo hash set of KEY_WIDTH-bit keys. A word is accepted when start_i is
// high and busy_o is low; its one-bit result appears on ok_o together with a one-cycle
// done_o strobe, and the receiver must take it then (no stall). Modes: insert, lookup,
// remove; the unused mode code finishes at once with ok_o low. Slot 1 is key mod SLOTS
// in table one, slot 2 is (key div SLOTS) mod SLOTS in table two. Both hashes come out
// of one shared multiplier (reciprocal multiply, then multiply back and subtract) that
// is stepped four times per key; the two table reads follow the hash pass. Lookup and
// remove give their result once both read entries are checked. Insert: one hash pass
// and table read per placement attempt, up to SLOTS attempts; a failed insert keeps
// its swaps and drops the last evicted key. After reset the block runs a clearing pass
// over all SLOTS entries of both tables with busy_o high.
module cuckoo_hash_table #(
  parameter int SLOTS     = 11,
  parameter int KEY_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  ckh_pkg::mode_t        mode_i,
  input  logic [KEY_WIDTH-1:0]  key_i,
  output logic                  done_o,
  output logic                  ok_o
);

  import ckh_pkg::*;

  // widths
  localparam int KW    = KEY_WIDTH;
  localparam int IW    = $clog2(SLOTS);
  localparam int SHIFT = KW + IW;
  localparam int MW    = (KW + 1 > IW + 1) ? KW + 1 : IW + 1;
  localparam int PW    = SHIFT + KW;
  localparam int EW    = KW + 1;

  // floor(k / SLOTS) == (k * MAGIC) >> SHIFT for every KW-bit k
  localparam logic [63:0]    POW     = 64'd1 << SHIFT;
  localparam logic [63:0]    MAGIC   = (POW + SLOTS - 1) / SLOTS;
  localparam logic [MW-1:0]  MAGIC_B = MAGIC[MW-1:0];
  localparam logic [MW-1:0]  SLOTS_B = MW'(SLOTS);
  localparam logic [IW-1:0]  LAST    = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HQ,   // k * magic
    ST_HR,   // q * slots
    ST_HS,   // q * magic, hash 1 out
    ST_HT,   // (q div slots) * slots
    ST_HU,   // hash 2 out, table reads issued
    ST_CHK   // read data back: decide, write
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          side_q, side_d;
  logic          done_q, done_d;
  logic          ok_q, ok_d;

  // datapath
  mode_t         mode_q, mode_d;
  logic [KW-1:0] cur_q, cur_d;     // carried key
  logic [KW-1:0] quo_q, quo_d;     // key div SLOTS
  logic [IW-1:0] h1_q, h1_d;
  logic [IW-1:0] h2_q, h2_d;
  logic [PW-1:0] prod_q;

  // shared multiplier
  logic [KW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  logic [IW-1:0] h1_c, h2_c;
  logic [KW-1:0] quo_c;

  // table ports
  logic          we1, we2;
  logic [IW-1:0] wa1, wa2, ra1, ra2;
  logic [EW-1:0] wd, rd1, rd2;

  logic          hit1, hit2, occ;
  logic [KW-1:0] evict;

  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign quo_c = prod_q[SHIFT +: KW];
  assign h1_c  = IW'(cur_q - prod_q[KW-1:0]);
  assign h2_c  = IW'(quo_q - prod_q[KW-1:0]);

  assign hit1  = rd1[KW] && (rd1[KW-1:0] == cur_q);
  assign hit2  = rd2[KW] && (rd2[KW-1:0] == cur_q);
  assign occ   = side_q ? rd2[KW] : rd1[KW];
  assign evict = side_q ? rd2[KW-1:0] : rd1[KW-1:0];

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    side_d  = side_q;
    done_d  = 1'b0;
    ok_d    = 1'b0;
    mode_d  = mode_q;
    cur_d   = cur_q;
    quo_d   = quo_q;
    h1_d    = h1_q;
    h2_d    = h2_q;
    mul_a   = cur_q;
    mul_b   = MAGIC_B;
    we1     = 1'b0;
    we2     = 1'b0;
    wa1     = h1_q;
    wa2     = h2_q;
    wd      = {1'b1, cur_q};
    ra1     = h1_q;
    ra2     = h2_q;

    unique case (state_q)
      ST_CLEAR: begin
        we1 = 1'b1;
        we2 = 1'b1;
        wa1 = clr_q;
        wa2 = clr_q;
        wd  = '0;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          mode_d = mode_i;
          cur_d  = key_i;
          side_d = 1'b0;
          cnt_d  = '0;
          case (mode_i) inside
            MODE_INSERT, MODE_LOOKUP, MODE_REMOVE: state_d = ST_HQ;
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_HQ: begin
        mul_a   = cur_q;
        mul_b   = MAGIC_B;
        state_d = ST_HR;
      end
      ST_HR: begin
        quo_d   = quo_c;
        mul_a   = quo_c;
        mul_b   = SLOTS_B;
        state_d = ST_HS;
      end
      ST_HS: begin
        h1_d    = h1_c;
        mul_a   = quo_q;
        mul_b   = MAGIC_B;
        state_d = ST_HT;
      end
      ST_HT: begin
        mul_a   = quo_c;
        mul_b   = SLOTS_B;
        state_d = ST_HU;
      end
      ST_HU: begin
        h2_d    = h2_c;
        ra1     = h1_q;
        ra2     = h2_c;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (mode_q == MODE_INSERT) begin
          // carried key always lands in the probed slot
          we1 = !side_q;
          we2 = side_q;
          if (!occ) begin
            done_d  = 1'b1;
            ok_d    = 1'b1;
            state_d = ST_IDLE;
          end else if (cnt_q == LAST) begin
            // out of attempts: evicted key is dropped
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cur_d   = evict;
            side_d  = !side_q;
            cnt_d   = cnt_q + IW'(1);
            state_d = ST_HQ;
          end
        end else begin
          wd      = '0;
          done_d  = 1'b1;
          ok_d    = hit1 || hit2;
          state_d = ST_IDLE;
          if (mode_q == MODE_REMOVE) begin
            we1 = hit1;
            we2 = !hit1 && hit2;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      side_q  <= 1'b0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      side_q  <= side_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cur_q  <= cur_d;
    quo_q  <= quo_d;
    h1_q   <= h1_d;
    h2_q   <= h2_d;
    prod_q <= mul_p;
  end

  ckh_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_tab1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(wa1),
    .wdata_i(wd),
    .raddr_i(ra1),
    .rdata_o(rd1)
  );

  ckh_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_tab2 (
    .clk_i  (clk_i),
    .we_i   (we2),
    .waddr_i(wa2),
    .wdata_i(wd),
    .raddr_i(ra2),
    .rdata_o(rd2)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign ok_o   = ok_q;

  // an accepted word either starts work or finishes in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted word neither started nor finished");

  // a result is only shown once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // ok is only ever raised together with the strobe
  a_ok_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_o |-> done_o)
    else $error("ok without result strobe");

endmodule

@@ verif/tb.sv @@
// Testbench for the cuckoo hash table: directed table plus random words, checked by a predictor.
`timescale 1ns / 100ps

module tb;
  import ckh_pkg::*;

  localparam int SLOTS = 11;
  localparam int KEY_W = 16;
  // Tail wait: one full failed insert plus a margin.
  localparam int SETTLE_CYCLES = 6 * SLOTS + 14;

  // Spare code: the block must finish it at once with ok low.
  localparam mode_t MODE_SPARE = 2'd3;

  typedef struct {
    mode_t           mode;
    logic [KEY_W-1:0] key;
    bit              typed;
    bit              typed_ok;
  } plan_row_t;

  typedef struct {
    bit          ok;
    int unsigned seq;
  } ok_due_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  mode_t            mode_i = MODE_INSERT;
  logic [KEY_W-1:0] key_i = '0;
  logic             busy_o;
  logic             done_o;
  logic             ok_o;

  // Side info for the word on the bus: a typed-in answer overrides the predictor.
  bit word_typed = 1'b0;
  bit word_typed_ok = 1'b0;

  // Predictor copy of both tables.
  logic [KEY_W-1:0] one_key [SLOTS];
  bit               one_used [SLOTS];
  logic [KEY_W-1:0] two_key [SLOTS];
  bit               two_used [SLOTS];

  ok_due_t          ok_due[$];
  logic [KEY_W-1:0] recent_keys[$];
  int unsigned      accepted_words = 0;
  int unsigned      mismatches = 0;

  // Directed words, run right after reset with the tables empty.
  plan_row_t plan[23] = '{
    '{MODE_LOOKUP, 16'h0000, 1'b1, 1'b0},  // empty table: miss
    '{MODE_REMOVE, 16'hFFFF, 1'b1, 1'b0},  // empty table: nothing to remove
    '{MODE_SPARE,  16'hFFFF, 1'b1, 1'b0},
    '{MODE_INSERT, 16'h0000, 1'b1, 1'b1},  // empty slot takes it
    '{MODE_LOOKUP, 16'h0000, 1'b1, 1'b1},
    '{MODE_INSERT, 16'hFFFF, 1'b0, 1'b0},
    '{MODE_LOOKUP, 16'hFFFF, 1'b0, 1'b0},
    '{MODE_INSERT, 16'd121,  1'b0, 1'b0},  // same two slots as key 0
    '{MODE_INSERT, 16'd242,  1'b0, 1'b0},  // third on those slots: insert fails
    '{MODE_LOOKUP, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOOKUP, 16'd121,  1'b0, 1'b0},
    '{MODE_LOOKUP, 16'd242,  1'b0, 1'b0},
    '{MODE_REMOVE, 16'd121,  1'b0, 1'b0},
    '{MODE_REMOVE, 16'd121,  1'b0, 1'b0},
    '{MODE_INSERT, 16'd5,    1'b0, 1'b0},
    '{MODE_INSERT, 16'd5,    1'b0, 1'b0},  // duplicate lands in a second slot
    '{MODE_REMOVE, 16'd5,    1'b0, 1'b0},
    '{MODE_LOOKUP, 16'd5,    1'b0, 1'b0},
    '{MODE_REMOVE, 16'd5,    1'b0, 1'b0},
    '{MODE_SPARE,  16'h0000, 1'b1, 1'b0},
    '{MODE_REMOVE, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOOKUP, 16'h5555, 1'b0, 1'b0},
    '{MODE_INSERT, 16'hAAAA, 1'b0, 1'b0}
  };

  cuckoo_hash_table #(
    .SLOTS    (SLOTS),
    .KEY_WIDTH(KEY_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .mode_i (mode_i),
    .key_i  (key_i),
    .done_o (done_o),
    .ok_o   (ok_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit cuckoo_insert(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] carried;
    logic [KEY_W-1:0] evicted;
    int               p;
    bit               on_two;
    carried = k;
    on_two  = 1'b0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!on_two) begin
        p = int'(carried) % SLOTS;
        if (!one_used[p]) begin
          one_key[p]  = carried;
          one_used[p] = 1'b1;
          return 1'b1;
        end
        evicted    = one_key[p];
        one_key[p] = carried;
      end else begin
        p = (int'(carried) / SLOTS) % SLOTS;
        if (!two_used[p]) begin
          two_key[p]  = carried;
          two_used[p] = 1'b1;
          return 1'b1;
        end
        evicted    = two_key[p];
        two_key[p] = carried;
      end
      carried = evicted;
      on_two  = !on_two;
    end
    // Out of attempts: swaps stay, the carried key is lost.
    return 1'b0;
  endfunction

  function automatic bit cuckoo_probe(input logic [KEY_W-1:0] k, input bit drop);
    int p;
    int q;
    p = int'(k) % SLOTS;
    q = (int'(k) / SLOTS) % SLOTS;
    if (one_used[p] && one_key[p] == k) begin
      if (drop) one_used[p] = 1'b0;
      return 1'b1;
    end
    if (two_used[q] && two_key[q] == k) begin
      if (drop) two_used[q] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit settle_word(input mode_t m, input logic [KEY_W-1:0] k);
    case (m)
      MODE_INSERT: return cuckoo_insert(k);
      MODE_LOOKUP: return cuckoo_probe(k, 1'b0);
      MODE_REMOVE: return cuckoo_probe(k, 1'b1);
      default:     return 1'b0;
    endcase
  endfunction

  // Accepted words and results are both taken from values sampled at the rising edge;
  // the push comes first, so a result in the accept cycle still finds its expectation.
  always @(posedge clk_i) begin : watch_block
    ok_due_t due;
    bit      got;
    if (rst_ni && start_i && !busy_o) begin
      got      = settle_word(mode_i, key_i);
      due.ok   = word_typed ? word_typed_ok : got;
      due.seq  = accepted_words;
      accepted_words++;
      ok_due.push_back(due);
    end
    if (rst_ni && done_o) begin
      if (ok_due.size() == 0) begin
        report_mismatch($sformatf("result ok=%b with no word pending", ok_o));
      end else begin
        due = ok_due.pop_front();
        if (ok_o !== due.ok)
          report_mismatch($sformatf("word %0d: ok=%b, want %b", due.seq, ok_o, due.ok));
      end
    end
  end

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      mode_i  <= mode_t'($urandom_range(0, 3));
      key_i   <= KEY_W'($urandom);
    end
  endtask

  task automatic issue(input mode_t m, input logic [KEY_W-1:0] k, input bit typed,
                       input bit typed_ok);
    @(negedge clk_i);
    start_i       <= 1'b1;
    mode_i        <= m;
    key_i         <= k;
    word_typed    <= typed;
    word_typed_ok <= typed_ok;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    if (m == MODE_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i    <= 1'b0;
    word_typed <= 1'b0;
    while (ok_due.size() != 0) @(posedge clk_i);
  endtask

  // Mostly keys that crowd a few slots, or keys inserted lately, so probes hit
  // and inserts evict; the rest spans the whole key range.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return KEY_W'(121 * $urandom_range(0, 7) + 11 * $urandom_range(0, 2) +
                    $urandom_range(0, 2));
    if (r < 80 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return MODE_INSERT;
    if (r < 70) return MODE_LOOKUP;
    if (r < 95) return MODE_REMOVE;
    return MODE_SPARE;
  endfunction

  initial begin : stimulus
    int idle_pct;
    int gap;
    for (int s = 0; s < SLOTS; s++) begin
      one_used[s] = 1'b0;
      two_used[s] = 1'b0;
      one_key[s]  = '0;
      two_key[s]  = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i])
      issue(plan[i].mode, plan[i].key, plan[i].typed, plan[i].typed_ok);
    drain();

    // Sender idles rarely, then often, then never; the receiver cannot stall.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 87 : 0;
      for (int i = 0; i < 560; i++) begin
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) hold_off(gap);
        issue(pick_mode(), pick_key(), 1'b0, 1'b0);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ok_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", ok_due.size()));
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ckh_pkg.sv
src/ckh_ram.sv
src/cuckoo_hash_table.sv
verif/tb.sv
